### sv/pbs_pkg.sv
`timescale 1ns / 1ps

package pbs_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SHUTDOWN_HOLD = 2'd0;
  localparam logic [1:0] REG_WAKE_HOLD     = 2'd1;
  localparam logic [1:0] REG_RELEASE_QUIET = 2'd2;

  // Register reset values, in ticks
  localparam logic [7:0] SHUTDOWN_HOLD_RST = 8'd100;
  localparam logic [7:0] WAKE_HOLD_RST     = 8'd50;
  localparam logic [7:0] RELEASE_QUIET_RST = 8'd10;

  // Phase codes as reported on the result channel
  localparam logic [2:0] PHASE_RUN      = 3'd0;
  localparam logic [2:0] PHASE_PRESLEEP = 3'd1;
  localparam logic [2:0] PHASE_SLEEP    = 3'd2;
  localparam logic [2:0] PHASE_WAKEHOLD = 3'd3;
  localparam logic [2:0] PHASE_PREBOOT  = 3'd4;
  localparam logic [2:0] PHASE_REBOOT   = 3'd5;

  // One tick sample
  typedef struct packed {
    logic button_pressed;
    logic poweroff_request;
  } in_item_t;

  // State after the tick
  typedef struct packed {
    logic       shutdown_request;
    logic [2:0] phase;
    logic       sleep_active;
    logic       reboot_now;
  } out_item_t;

endpackage

### sv/power_button_sequencer_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    in_data   (in_item_t, one 10 ms tick)
// out_     output     out_valid/out_ready  out_data  (out_item_t, state after tick)
// cfg_     input      cfg_we               cfg_index, cfg_wdata (8 bits)
//
// One tick is accepted per cycle while in_ready is high; its result appears in
// the output register on the next cycle.
// in_ready is low only while a result waits and out_ready is low; the output
// register alone decides the stall.
// Synchronous active-low reset returns phase to running, clears the counter
// and the shutdown latch, and loads the register defaults 100, 50 and 10.

module power_button_sequencer_top
  import pbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_RUN      = PHASE_RUN,
    ST_PRESLEEP = PHASE_PRESLEEP,
    ST_SLEEP    = PHASE_SLEEP,
    ST_WAKEHOLD = PHASE_WAKEHOLD,
    ST_PREBOOT  = PHASE_PREBOOT,
    ST_REBOOT   = PHASE_REBOOT
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       sd_r, sd_nxt;
  logic [7:0] shutdown_hold_r, wake_hold_r, release_quiet_r;
  logic       out_valid_r;
  out_item_t  out_data_r, out_data_nxt;

  logic       in_fire;
  logic [7:0] cnt_inc;
  logic [7:0] eff_shutdown, eff_wake, eff_quiet;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Saturating increment and zero-as-one thresholds
  assign cnt_inc      = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
  assign eff_shutdown = (shutdown_hold_r == 8'd0) ? 8'd1 : shutdown_hold_r;
  assign eff_wake     = (wake_hold_r == 8'd0) ? 8'd1 : wake_hold_r;
  assign eff_quiet    = (release_quiet_r == 8'd0) ? 8'd1 : release_quiet_r;

  // Advance the sequencer by one tick
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sd_nxt    = sd_r;
    case (state_r)
      ST_RUN: begin
        if (!sd_r) begin
          if (in_data.button_pressed) begin
            if (cnt_inc >= eff_shutdown) begin
              sd_nxt  = 1'b1;
              cnt_nxt = 8'd0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end else begin
            cnt_nxt = 8'd0;
          end
        end
        // request tick itself never counts as quiet
        if (in_data.poweroff_request) begin
          state_nxt = ST_PRESLEEP;
          cnt_nxt   = 8'd0;
        end
      end
      ST_PRESLEEP, ST_PREBOOT: begin
        if (in_data.button_pressed) begin
          cnt_nxt = 8'd0;
        end else if (cnt_inc >= eff_quiet) begin
          cnt_nxt   = 8'd0;
          state_nxt = (state_r == ST_PRESLEEP) ? ST_SLEEP : ST_REBOOT;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      ST_SLEEP: begin
        // waking press is the first hold tick
        if (in_data.button_pressed) begin
          if (eff_wake == 8'd1) begin
            cnt_nxt   = 8'd0;
            state_nxt = ST_PREBOOT;
          end else begin
            cnt_nxt   = 8'd1;
            state_nxt = ST_WAKEHOLD;
          end
        end
      end
      ST_WAKEHOLD: begin
        if (in_data.button_pressed) begin
          if (cnt_inc >= eff_wake) begin
            cnt_nxt   = 8'd0;
            state_nxt = ST_PREBOOT;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end else begin
          cnt_nxt   = 8'd0;
          state_nxt = ST_SLEEP;
        end
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  // Build the result from the state after the tick
  always_comb begin
    out_data_nxt.shutdown_request = sd_nxt;
    out_data_nxt.phase            = state_nxt;
    out_data_nxt.sleep_active     = (state_nxt == ST_SLEEP);
    out_data_nxt.reboot_now       = (state_nxt == ST_REBOOT);
  end

  // Hold state, registers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_RUN;
      cnt_r           <= 8'd0;
      sd_r            <= 1'b0;
      shutdown_hold_r <= SHUTDOWN_HOLD_RST;
      wake_hold_r     <= WAKE_HOLD_RST;
      release_quiet_r <= RELEASE_QUIET_RST;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SHUTDOWN_HOLD: shutdown_hold_r <= cfg_wdata;
          REG_WAKE_HOLD:     wake_hold_r     <= cfg_wdata;
          REG_RELEASE_QUIET: release_quiet_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        state_r     <= state_nxt;
        cnt_r       <= cnt_nxt;
        sd_r        <= sd_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result on every input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_shutdown_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sd_r |=> sd_r)
    else $error("shutdown latch dropped without reset");

  a_reboot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REBOOT) |=> (state_r == ST_REBOOT))
    else $error("reboot phase left without reset");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r && (out_data_r.phase == state_r)
      && (out_data_r.shutdown_request == sd_r))
    else $error("result does not match updated state");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_data_r)
      && $stable(state_r))
    else $error("stalled result or state changed");
`endif

endmodule

### test/power_button_sequencer_top_test.sv
`timescale 1ns / 1ps

module power_button_sequencer_top_test;
  import pbs_pkg::*;

  // Cycles with no transfer on either channel before the run is abandoned
  localparam int STALL_LIMIT  = 2000;
  // Extra cycles after the last result before a register write or the end
  localparam int DRAIN_CYCLES = 3;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // Tracks the sequencer state per tick and holds the states still owed
  class phase_scoreboard;
    logic [7:0] shutdown_hold;
    logic [7:0] wake_hold;
    logic [7:0] quiet_ticks;
    logic [2:0] phase;
    logic [7:0] count;
    logic       latched;
    out_item_t  expected_states[$];
    int         mismatches;

    function new();
      shutdown_hold = SHUTDOWN_HOLD_RST;
      wake_hold     = WAKE_HOLD_RST;
      quiet_ticks   = RELEASE_QUIET_RST;
      phase         = PHASE_RUN;
      count         = 8'd0;
      latched       = 1'b0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_SHUTDOWN_HOLD: shutdown_hold = val;
        REG_WAKE_HOLD:     wake_hold = val;
        REG_RELEASE_QUIET: quiet_ticks = val;
        default: ;
      endcase
    endfunction

    // A threshold of zero behaves as one
    function logic [7:0] floor_one(logic [7:0] r);
      return (r == 8'd0) ? 8'd1 : r;
    endfunction

    function logic [7:0] sat_inc(logic [7:0] c);
      return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    // Count quiet ticks; a press restarts the wait
    function bit quiet_done(logic pressed);
      if (pressed) begin
        count = 8'd0;
        return 1'b0;
      end
      count = sat_inc(count);
      if (count >= floor_one(quiet_ticks)) begin
        count = 8'd0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_tick(in_item_t t);
      out_item_t want;
      case (phase)
        PHASE_RUN: begin
          // Press count first, then the power-off request
          if (!latched) begin
            if (t.button_pressed) begin
              count = sat_inc(count);
              if (count >= floor_one(shutdown_hold)) begin
                latched = 1'b1;
                count   = 8'd0;
              end
            end else begin
              count = 8'd0;
            end
          end
          if (t.poweroff_request) begin
            phase = PHASE_PRESLEEP;
            count = 8'd0;
          end
        end
        PHASE_PRESLEEP: begin
          if (quiet_done(t.button_pressed)) phase = PHASE_SLEEP;
        end
        PHASE_SLEEP: begin
          // The waking press is the first hold tick
          if (t.button_pressed) begin
            count = 8'd1;
            if (count >= floor_one(wake_hold)) begin
              count = 8'd0;
              phase = PHASE_PREBOOT;
            end else begin
              phase = PHASE_WAKEHOLD;
            end
          end
        end
        PHASE_WAKEHOLD: begin
          if (t.button_pressed) begin
            count = sat_inc(count);
            if (count >= floor_one(wake_hold)) begin
              count = 8'd0;
              phase = PHASE_PREBOOT;
            end
          end else begin
            count = 8'd0;
            phase = PHASE_SLEEP;
          end
        end
        PHASE_PREBOOT: begin
          if (quiet_done(t.button_pressed)) phase = PHASE_REBOOT;
        end
        default: ;
      endcase
      want.shutdown_request = latched;
      want.phase            = phase;
      want.sleep_active     = (phase == PHASE_SLEEP);
      want.reboot_now       = (phase == PHASE_REBOOT);
      expected_states.push_back(want);
    endfunction

    function void check_state(out_item_t got);
      out_item_t want;
      if (expected_states.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: shutdown=%0b phase=%0d sleep=%0b reboot=%0b",
                   got.shutdown_request, got.phase, got.sleep_active, got.reboot_now);
        return;
      end
      want = expected_states.pop_front();
      if (got.shutdown_request !== want.shutdown_request ||
          got.phase !== want.phase ||
          got.sleep_active !== want.sleep_active ||
          got.reboot_now !== want.reboot_now) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected shutdown=%0b phase=%0d sleep=%0b reboot=%0b,",
                   want.shutdown_request, want.phase, want.sleep_active, want.reboot_now,
                   " got shutdown=%0b phase=%0d sleep=%0b reboot=%0b",
                   got.shutdown_request, got.phase, got.sleep_active, got.reboot_now);
      end
    endfunction

    function int pending();
      return expected_states.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  phase_scoreboard sb;
  idle_mode_t      idle_mode;
  int              ticks_sent;
  int              quiet_cycles;

  power_button_sequencer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned stall_percent(idle_mode_t m, bit receiver);
    case (m)
      IDLE_SENDER:   return receiver ? 0 : 50;
      IDLE_RECEIVER: return receiver ? 50 : 0;
      IDLE_BOTH:     return 10;
      default:       return 0;
    endcase
  endfunction

  function automatic bit chance(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= !chance(stall_percent(idle_mode, 1'b1));
  end

  // Check each result transfer; drop the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_state(out_data);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Offer one tick, hold it until the transfer, then maybe go idle
  task automatic send_tick(input logic pressed, input logic req);
    in_item_t item;
    item.button_pressed   = pressed;
    item.poweroff_request = req;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(item);
    ticks_sent++;
    idle_mode = idle_mode_t'((ticks_sent / 37) % 4);
    if (chance(stall_percent(idle_mode, 1'b0))) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every owed state has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic noise_ticks(input int n, input int unsigned press_pct,
                             input int unsigned req_pct);
    repeat (n) send_tick(chance(press_pct), chance(req_pct));
  endtask

  // Alternate runs of one level and the other, each run one to lead_max or trail_max ticks long
  task automatic burst_ticks(input int n, input logic lead, input int lead_max,
                             input int trail_max);
    int sent;
    sent = 0;
    while (sent < n) begin
      repeat ($urandom_range(lead_max, 1)) begin
        send_tick(lead, chance(50));
        sent++;
      end
      repeat ($urandom_range(trail_max, 1)) begin
        send_tick(!lead, chance(50));
        sent++;
      end
    end
  endtask

  initial begin
    sb         = new();
    ticks_sent = 0;
    idle_mode  = IDLE_NONE;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SHUTDOWN_HOLD;
    cfg_wdata <= 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Running with default thresholds
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);

    // Long shutdown hold: presses broken up before the latch
    settle();
    write_reg(REG_SHUTDOWN_HOLD, 8'd255);
    noise_ticks(100, 80, 0);

    // Exact hold count; the latching press carries the power-off request
    settle();
    write_reg(REG_SHUTDOWN_HOLD, 8'd5);
    send_tick(1'b0, 1'b0);
    repeat (4) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    repeat (4) send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);

    // Pre-sleep release wait
    settle();
    write_reg(REG_SHUTDOWN_HOLD, 8'd1);
    write_reg(REG_RELEASE_QUIET, 8'd255);
    noise_ticks(60, 30, 50);
    settle();
    write_reg(REG_RELEASE_QUIET, 8'd5);
    burst_ticks(60, 1'b0, 4, 3);

    // Zero quiet threshold acts as one
    settle();
    write_reg(REG_RELEASE_QUIET, 8'd0);
    send_tick(1'b1, 1'b1);
    while (sb.phase == PHASE_PRESLEEP) send_tick(1'b0, chance(50));
    send_tick(1'b0, 1'b1);

    // Sleep and wake-hold loop
    settle();
    write_reg(REG_WAKE_HOLD, 8'd255);
    noise_ticks(100, 50, 50);
    settle();
    write_reg(REG_WAKE_HOLD, 8'd6);
    while (sb.phase == PHASE_WAKEHOLD) send_tick(1'b0, 1'b0);
    repeat (5) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    burst_ticks(150, 1'b1, 5, 3);
    settle();
    write_reg(REG_WAKE_HOLD, 8'd2);
    while (sb.phase == PHASE_WAKEHOLD) send_tick(1'b0, 1'b0);
    burst_ticks(40, 1'b1, 1, 2);

    // The waking press alone meets the hold count
    settle();
    write_reg(REG_WAKE_HOLD, 8'd1);
    while (sb.phase == PHASE_WAKEHOLD) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);

    // Pre-reboot release wait
    settle();
    write_reg(REG_RELEASE_QUIET, 8'd255);
    noise_ticks(80, 25, 50);
    settle();
    write_reg(REG_RELEASE_QUIET, 8'd3);
    burst_ticks(40, 1'b0, 2, 2);
    while (sb.phase == PHASE_PREBOOT) send_tick(1'b0, chance(50));

    // Reboot holds whatever comes in
    noise_ticks(10, 50, 50);

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
